// ----- rtl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// Used by the top level and the read address splitter; no dependencies.
package tcw_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int ROWS_DEF    = 16;

  localparam int ADDR_W = 9;
  localparam int DATA_W = 8;

  localparam logic [DATA_W-1:0] BLANK    = 8'h20;
  localparam logic [DATA_W-1:0] CHAR_CR  = 8'h0d;
  localparam logic [DATA_W-1:0] CHAR_LF  = 8'h0a;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] char_code;
    logic [ADDR_W-1:0] read_address;
  } tcw_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [ADDR_W-1:0] cursor_position;
    logic              scrolled;
  } tcw_rsp_t;

  // Row and column of a read address, registered, with a one-cycle done pulse.
  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
  } tcw_split_t;

  function automatic logic [DATA_W-1:0] to_upper(input logic [DATA_W-1:0] b);
    if (b inside {[8'h61:8'h7a]}) begin
      return b - 8'h20;
    end
    return b;
  endfunction

endpackage

// ----- rtl/tcw_addr_split.sv -----
// Splits a linear cell address into row and column; estimate and result are registered.
// Reciprocal multiply, one registered back-multiply and one correction step.
// Depends on tcw_pkg.
module tcw_addr_split #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           go_i,
  input  logic [tcw_pkg::ADDR_W-1:0]     addr_i,
  output tcw_pkg::tcw_split_t            split_o
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int SH = 2 * AW;
  localparam int PW = AW + SH;
  localparam int BW = 2 * AW;
  localparam logic [SH-1:0] RECIP  = SH'((1 << SH) / COLUMNS);
  localparam logic [BW-1:0] COLS_W = BW'(COLUMNS);

  logic [PW-1:0] prod;
  logic [AW-1:0] q_est_q;
  logic [AW-1:0] addr_q;
  logic          pend_q;
  logic [BW-1:0] back;
  logic [BW-1:0] rem;
  logic [AW-1:0] row_d;
  logic [AW-1:0] col_d;
  tcw_pkg::tcw_split_t split_q;

  // Estimate is exact or one low.
  assign prod = PW'(addr_i) * PW'(RECIP);

  always_comb begin
    back = BW'(q_est_q) * COLS_W;
    rem  = BW'(addr_q) - back;
    if (rem >= COLS_W) begin
      row_d = q_est_q + 1'b1;
      col_d = AW'(rem - COLS_W);
    end else begin
      row_d = q_est_q;
      col_d = AW'(rem);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= 1'b0;
      q_est_q      <= '0;
      addr_q       <= '0;
      split_q      <= '0;
    end else begin
      pend_q       <= go_i;
      split_q.done <= pend_q;
      if (go_i) begin
        q_est_q <= prod[PW-1:SH];
        addr_q  <= addr_i;
      end
      if (pend_q) begin
        split_q.row <= row_d;
        split_q.col <= col_d;
      end
    end
  end

  assign split_o = split_q;

endmodule

// ----- rtl/text_console_writer_with_scroll_core.sv -----
// Text console writer: character store with cursor and row-offset scrolling.
// Depends on tcw_pkg and tcw_addr_split.
//
// Usage
//   An item is taken on a rising edge with start high and busy low. A put item
//   (req_type 0) writes char_code at the cursor, upper-cased, or for CR/LF moves
//   to the next row; a read item (req_type 1) fetches the cell at read_address.
//   Each item gives one result on rsp_o, held for exactly one cycle and marked
//   by rsp_valid_o. The receiver cannot stall; none is needed, as the result
//   register is loaded only once per item and busy is low while it is shown.
//   Steps from the accept edge to the result being shown:
//     put of a character : the one write to the cell memory
//     put of CR/LF       : one blank written per cycle to the rest of the row
//     read               : the row/column split, the memory's registered
//                          read, then forming the item
//   A new item may be taken in the cycle its predecessor's result is shown.
//   Scrolling moves a top-row pointer instead of copying rows, so it adds no
//   extra steps. Cells past the cursor read as spaces, so the memory needs no
//   clearing pass: after reset it is usable at once, store all spaces, cursor 0.
module text_console_writer_with_scroll_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  tcw_pkg::tcw_req_t req_i,
  output logic              busy,
  output tcw_pkg::tcw_rsp_t rsp_o,
  output logic              rsp_valid_o
);

  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int MW     = RW + CW;
  localparam int DEPTH  = 1 << MW;
  localparam int CELLS  = COLUMNS * ROWS;
  localparam int LW     = $clog2(CELLS);
  localparam int AW     = tcw_pkg::ADDR_W;
  localparam int DW     = tcw_pkg::DATA_W;
  localparam logic [LW-1:0] LAST_BASE = LW'((ROWS - 1) * COLUMNS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [RW:0]   ROWS_W    = (RW + 1)'(ROWS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUT,
    S_RD_DIV,
    S_RD_OUT
  } state_e;

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    return (r == LAST_ROW) ? '0 : r + 1'b1;
  endfunction

  state_e state_q;

  // Cursor: logical row/column, physical memory row and linear index.
  logic [CW-1:0] cur_col_q;
  logic [RW-1:0] cur_row_q;
  logic [RW-1:0] cur_prow_q;
  logic [LW-1:0] cur_lin_q;
  // Physical memory row holding logical row 0.
  logic [RW-1:0] top_q;

  logic [DW-1:0] char_q;
  logic          nl_q;
  logic          rd_in_range_q;
  logic          rd_live_q;

  tcw_pkg::tcw_rsp_t rsp_q;
  logic              rsp_valid_q;

  tcw_pkg::tcw_split_t split;
  logic                split_go;

  // Memory, one write and one read port, registered read.
  logic [DW-1:0] screen_mem_q [DEPTH];
  logic          mem_we;
  logic [MW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [MW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata_q;

  // Put step and read address decode.
  logic          col_wrap;
  logic          put_last;
  logic          put_scroll;
  logic [LW-1:0] lin_nxt;
  logic [RW-1:0] rd_lrow;
  logic [CW-1:0] rd_col;
  logic [RW:0]   rd_psum;
  logic [RW-1:0] rd_prow;
  logic          rd_live;

  assign busy     = (state_q != S_IDLE);
  assign split_go = start && !busy && (req_i.req_type == tcw_pkg::REQ_READ);

  tcw_addr_split #(
    .COLUMNS (COLUMNS)
  ) u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (split_go),
    .addr_i  (req_i.read_address),
    .split_o (split)
  );

  always_comb begin
    // A newline is a run of blanks up to the row end; only the last one counts.
    col_wrap   = (cur_col_q == LAST_COL);
    put_last   = !nl_q || col_wrap;
    put_scroll = col_wrap && (cur_row_q == LAST_ROW);
    lin_nxt    = put_scroll ? LAST_BASE : cur_lin_q + 1'b1;

    mem_we    = (state_q == S_PUT);
    mem_waddr = {cur_prow_q, cur_col_q};
    mem_wdata = nl_q ? tcw_pkg::BLANK : tcw_pkg::to_upper(char_q);

    // Logical to physical row through the top-row pointer.
    rd_lrow   = split.row[RW-1:0];
    rd_col    = split.col[CW-1:0];
    rd_psum   = {1'b0, rd_lrow} + {1'b0, top_q};
    rd_prow   = (rd_psum >= ROWS_W) ? RW'(rd_psum - ROWS_W) : rd_psum[RW-1:0];
    mem_re    = (state_q == S_RD_DIV) && split.done;
    mem_raddr = {rd_prow, rd_col};
    // Cells at or past the cursor have not been written since they went blank.
    rd_live   = (rd_lrow < cur_row_q) || ((rd_lrow == cur_row_q) && (rd_col < cur_col_q));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= screen_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cur_col_q     <= '0;
      cur_row_q     <= '0;
      cur_prow_q    <= '0;
      cur_lin_q     <= '0;
      top_q         <= '0;
      char_q        <= '0;
      nl_q          <= 1'b0;
      rd_in_range_q <= 1'b0;
      rd_live_q     <= 1'b0;
      rsp_q         <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            char_q        <= req_i.char_code;
            nl_q          <= (req_i.char_code == tcw_pkg::CHAR_CR) ||
                             (req_i.char_code == tcw_pkg::CHAR_LF);
            rd_in_range_q <= (32'(req_i.read_address) < CELLS);
            state_q       <= (req_i.req_type == tcw_pkg::REQ_READ) ? S_RD_DIV : S_PUT;
          end
        end
        S_PUT: begin
          cur_lin_q <= lin_nxt;
          if (col_wrap) begin
            cur_col_q  <= '0;
            cur_prow_q <= row_inc(cur_prow_q);
            if (put_scroll) begin
              top_q <= row_inc(top_q);
            end else begin
              cur_row_q <= cur_row_q + 1'b1;
            end
          end else begin
            cur_col_q <= cur_col_q + 1'b1;
          end
          if (put_last) begin
            rsp_q.read_data       <= '0;
            rsp_q.cursor_position <= AW'(lin_nxt);
            rsp_q.scrolled        <= put_scroll;
            rsp_valid_q           <= 1'b1;
            state_q               <= S_IDLE;
          end
        end
        S_RD_DIV: begin
          if (split.done) begin
            rd_live_q <= rd_live;
            state_q   <= S_RD_OUT;
          end
        end
        S_RD_OUT: begin
          if (!rd_in_range_q) begin
            rsp_q.read_data <= '0;
          end else if (rd_live_q) begin
            rsp_q.read_data <= mem_rdata_q;
          end else begin
            rsp_q.read_data <= tcw_pkg::BLANK;
          end
          rsp_q.cursor_position <= AW'(cur_lin_q);
          rsp_q.scrolled        <= 1'b0;
          rsp_valid_q           <= 1'b1;
          state_q               <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the text console writer core.
// Depends on tcw_pkg and text_console_writer_with_scroll_core; stands alone.
`timescale 1ns / 100ps

module tb;
  import tcw_pkg::*;

  localparam int COLS      = COLUMNS_DEF;
  localparam int LINES     = ROWS_DEF;
  localparam int CELLS     = COLS * LINES;
  // slowest item is a newline from column 0, which blanks the whole row
  localparam int SETTLE    = 2 * COLS + 8;
  localparam int LIMIT     = 200000;
  localparam int RAND_BLKS = 8;
  localparam int BLK_ITEMS = 50;

  // Scoreboard: own copy of the store and cursor, plus the queue of
  // responses still to come, oldest first.
  class console_scoreboard;
    logic [DATA_W-1:0] cells [CELLS];
    int unsigned       cursor;
    tcw_rsp_t          pending_rsp [$];
    int unsigned       errors;
    int unsigned       n_put, n_read, n_newline, n_scroll, n_checked;

    function void clear();
      for (int i = 0; i < CELLS; i++) cells[i] = BLANK;
      cursor = 0;
      pending_rsp.delete();
      errors = 0;
      n_put = 0; n_read = 0; n_newline = 0; n_scroll = 0; n_checked = 0;
    endfunction

    function int outstanding();
      return pending_rsp.size();
    endfunction

    // Work out the response an accepted item causes, and update the store.
    function void note_request(tcw_req_t req);
      tcw_rsp_t          rsp;
      int unsigned       nxt;
      logic [DATA_W-1:0] ch;
      rsp = '0;
      if (req.req_type == REQ_READ) begin
        n_read++;
        if (int'(req.read_address) < CELLS) rsp.read_data = cells[req.read_address];
      end else begin
        n_put++;
        ch = req.char_code;
        if (ch == CHAR_CR || ch == CHAR_LF) begin
          n_newline++;
          nxt = (cursor / COLS + 1) * COLS;
        end else begin
          if (ch >= 8'h61 && ch <= 8'h7a) ch = ch - 8'h20;
          cells[cursor] = ch;
          nxt = cursor + 1;
        end
        if (nxt >= CELLS) begin
          // store moves up a row, bottom row blanked
          for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = BLANK;
          nxt = CELLS - COLS;
          rsp.scrolled = 1'b1;
          n_scroll++;
        end
        cursor = nxt;
      end
      rsp.cursor_position = ADDR_W'(cursor);
      pending_rsp.push_back(rsp);
    endfunction

    function void check_response(tcw_rsp_t got);
      tcw_rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("response with no item outstanding: %h", got);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      n_checked++;
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        errors++;
      end
      if (got.cursor_position !== want.cursor_position) begin
        $error("cursor_position: expected %0d, got %0d",
               want.cursor_position, got.cursor_position);
        errors++;
      end
      if (got.scrolled !== want.scrolled) begin
        $error("scrolled: expected %b, got %b", want.scrolled, got.scrolled);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  tcw_req_t req_q;
  logic     busy;
  tcw_rsp_t rsp_o;
  logic     rsp_valid_o;

  console_scoreboard sb;
  int unsigned       cycle_count;

  text_console_writer_with_scroll_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_q),
    .busy        (busy),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Results cannot be held off: sample every strobe at the edge ending it.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) sb.check_response(rsp_o);
  end

  // Watchdog: generous bound over the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("FAIL text_console_writer_with_scroll_core");
      $finish;
    end
  end

  function automatic tcw_req_t put_item(logic [DATA_W-1:0] code);
    tcw_req_t r;
    r.req_type     = REQ_PUT;
    r.char_code    = code;
    r.read_address = ADDR_W'($urandom_range(0, 511)); // ignored on a put
    return r;
  endfunction

  function automatic tcw_req_t read_item(logic [ADDR_W-1:0] addr);
    tcw_req_t r;
    r.req_type     = REQ_READ;
    r.char_code    = DATA_W'($urandom_range(0, 255)); // ignored on a read
    r.read_address = addr;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random item: reads and puts of lowercase, printable, newline and raw bytes.
  function automatic tcw_req_t random_item();
    tcw_req_t r;
    int       sel;
    sel = $urandom_range(0, 99);
    r   = put_item(DATA_W'($urandom_range(0, 255)));
    if (sel < 35) begin
      // a third of reads land on the bottom rows, where the writing goes on
      if ($urandom_range(0, 2) == 0) begin
        r = read_item(ADDR_W'($urandom_range(CELLS - 2 * COLS, CELLS - 1)));
      end else begin
        r = read_item(ADDR_W'($urandom_range(0, 511)));
      end
    end else if (sel < 47) begin
      r.char_code = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    end else if (sel < 70) begin
      r.char_code = DATA_W'($urandom_range(8'h61, 8'h7a));
    end else if (sel < 90) begin
      r.char_code = DATA_W'($urandom_range(8'h20, 8'h7e));
    end
    return r;
  endfunction

  // Present one item from a falling edge and hold it until it is taken;
  // returns at a falling edge after the requested idle gap.
  task automatic send_item(tcw_req_t r, int gap);
    start <= 1'b1;
    req_q <= r;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      req_q <= tcw_req_t'($urandom());
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Hold off the sender until every outstanding response has come back.
  task automatic wait_drained();
    if (start) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  initial begin
    tcw_req_t directed [$];
    bit       burst;

    sb          = new();
    sb.clear();
    cycle_count = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_q       = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: blank store after reset at both ends, case folding limits,
    // bytes at the extremes, CR, then LF down to and past the last row.
    directed.push_back(read_item(9'd0));
    directed.push_back(read_item(9'h1ff));
    directed.push_back(put_item(8'h61));   // 'a'
    directed.push_back(put_item(8'h7a));   // 'z'
    directed.push_back(put_item(8'h60));   // just below 'a'
    directed.push_back(put_item(8'h7b));   // just above 'z'
    directed.push_back(put_item(8'h00));
    directed.push_back(put_item(8'hff));   // high bytes kept as they are
    directed.push_back(put_item(CHAR_CR));
    for (int i = 0; i < LINES - 1; i++) directed.push_back(put_item(CHAR_LF));
    directed.push_back(read_item(9'd0));   // top row after the scroll
    foreach (directed[i]) send_item(directed[i], idle_gap());

    wait_drained();

    // Random blocks; every fourth is back to back with no idling.
    for (int b = 0; b < RAND_BLKS; b++) begin
      burst = (b % 4 == 3);
      for (int i = 0; i < BLK_ITEMS; i++) send_item(random_item(), burst ? 0 : idle_gap());
      if (b == RAND_BLKS / 2 - 1) wait_drained();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);

    $display("covered %0d puts (%0d newlines) and %0d reads; %0d scrolls",
             sb.n_put, sb.n_newline, sb.n_read, sb.n_scroll);
    $display("responses checked: %0d, mismatches: %0d", sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS text_console_writer_with_scroll_core");
    end else begin
      $display("FAIL text_console_writer_with_scroll_core");
    end
    $finish;
  end

endmodule

// ----- text_console_writer_with_scroll_core.f -----
rtl/tcw_pkg.sv
rtl/tcw_addr_split.sv
rtl/text_console_writer_with_scroll_core.sv
sim/tb.sv
